/* rtl/core/kli_pkg.sv */
// ----------------------------------------------------------------------------
// kli_pkg: shared types and constants for the keyed list
// Opcodes, status codes, cell actions, controller states and the control
// struct that the controller broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package kli_pkg;

	localparam int DATA_W  = 32;
	localparam int COUNT_W = 7;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_QUERY  = 2'd1,
		OP_INSERT = 2'd2,
		OP_DELETE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ACT_HOLD,
		ACT_APPEND,
		ACT_INSERT,
		ACT_DELETE
	} act_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_COMMIT
	} state_t;

	typedef struct packed {
		logic search;
		act_t act;
	} cell_ctrl_t;

endpackage

/* rtl/core/kli_cell.sv */
// ----------------------------------------------------------------------------
// kli_cell: one entry of the keyed list
// Holds one value, compares it against the key and moves data to or from
// its neighbors when the list is shifted. Cell 0 holds the tail entry.
// ----------------------------------------------------------------------------
module kli_cell #(
	parameter int INDEX = 0,
	parameter int CNT_W = 7
) (
	input  logic                             clk,
	input  kli_pkg::cell_ctrl_t              ctrl,
	input  logic [CNT_W-1:0]                 count,
	input  logic signed [kli_pkg::DATA_W-1:0] key,
	input  logic signed [kli_pkg::DATA_W-1:0] new_value,
	input  logic signed [kli_pkg::DATA_W-1:0] left_value,
	input  logic signed [kli_pkg::DATA_W-1:0] right_value,
	input  logic                             left_match,
	input  logic                             above_in,
	output logic                             above_out,
	output logic                             match,
	output logic                             match_nxt,
	output logic signed [kli_pkg::DATA_W-1:0] value,
	output logic signed [kli_pkg::DATA_W-1:0] value_nxt
);
	import kli_pkg::*;

	logic signed [DATA_W-1:0] value_q;
	logic                     match_q;
	logic                     above_here;

	// The list head sits at the highest occupied cell, so the first match
	// counted from the head is the highest matching cell.
	assign above_here = above_in | match_q;
	assign above_out  = above_here;
	assign match      = match_q;
	assign value      = value_q;
	assign match_nxt  = (CNT_W'(INDEX) < count) && (value_q == key);

	always_comb begin
		value_nxt = value_q;
		unique case (ctrl.act)
			ACT_HOLD: begin
				value_nxt = value_q;
			end
			ACT_APPEND: begin
				value_nxt = left_value;
			end
			ACT_INSERT: begin
				// Cells above the matching one move up; the cell just above
				// it takes the new value.
				if (!(above_here || left_match)) begin
					value_nxt = left_value;
				end else if (left_match && !above_here) begin
					value_nxt = new_value;
				end else begin
					value_nxt = value_q;
				end
			end
			ACT_DELETE: begin
				if (!above_in) begin
					value_nxt = right_value;
				end else begin
					value_nxt = value_q;
				end
			end
			default: begin
				value_nxt = value_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_nxt;
		if (ctrl.search) begin
			match_q <= match_nxt;
		end
	end

endmodule

/* rtl/core/keyed_list_insert_delete.sv */
// ----------------------------------------------------------------------------
// keyed_list_insert_delete: ordered list of signed 32-bit values
// Append, query, insert before key and delete by key over a chain of cells,
// with one result beat per input beat.
// ----------------------------------------------------------------------------
// Each item goes through a search step and a commit step: in the first,
// every cell compares its entry with the key at once; in the second, the
// controller resolves the status and all cells shift or hold in one pass
// along the chain. The next item is taken in the same cycle as that second
// step, so a new item is not taken before the last one finishes. The result
// sits in an output register, but a stalled result holds the finishing step
// and with it the acceptance of the next beat. Entries are held in cell 0
// (tail) upward; CAPACITY sets the number of cells.
module keyed_list_insert_delete #(
	parameter int CAPACITY = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        opcode,
	input  logic signed [kli_pkg::DATA_W-1:0] key,
	input  logic signed [kli_pkg::DATA_W-1:0] new_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        status,
	output logic [kli_pkg::COUNT_W-1:0]       count,
	output logic signed [kli_pkg::DATA_W-1:0] last_value
);
	import kli_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	state_t state_q, state_d;

	op_t                    op_q;
	logic signed [DATA_W-1:0] key_q;
	logic signed [DATA_W-1:0] val_q;
	logic                   hit_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       count_d;
	status_t                status_d;
	act_t                   act_d;
	cell_ctrl_t             ctrl;

	logic                   out_valid_q;
	status_t                status_q;
	logic [CNT_W-1:0]       count_out_q;
	logic signed [DATA_W-1:0] last_q;
	logic signed [DATA_W-1:0] last_d;
	logic [CNT_W+COUNT_W-1:0] count_ext;

	logic                   accept;
	logic                   commit_go;

	logic signed [DATA_W-1:0] cell_value     [CAPACITY];
	logic signed [DATA_W-1:0] cell_value_nxt [CAPACITY];
	logic [CAPACITY-1:0]      cell_match;
	logic [CAPACITY-1:0]      cell_match_nxt;
	logic [CAPACITY:0]        above_chain;

	assign commit_go = (state_q == S_COMMIT) && (!out_valid_q || out_ready);
	assign in_ready  = (state_q == S_IDLE) || commit_go;
	assign accept    = in_valid && in_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (commit_go) begin
					state_d = in_valid ? S_SEARCH : S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Status, new count and cell action for the item in hand.
	always_comb begin
		status_d = STAT_OK;
		count_d  = count_q;
		act_d    = ACT_HOLD;
		unique case (op_q)
			OP_APPEND: begin
				if (count_q == CNT_W'(CAPACITY)) begin
					status_d = STAT_FULL;
				end else begin
					act_d   = ACT_APPEND;
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_QUERY: begin
				if (count_q == '0) begin
					status_d = STAT_EMPTY;
				end
			end
			OP_INSERT: begin
				if (!hit_q) begin
					status_d = STAT_NOT_FOUND;
				end else if (count_q == CNT_W'(CAPACITY)) begin
					status_d = STAT_FULL;
				end else begin
					act_d   = ACT_INSERT;
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_DELETE: begin
				if (!hit_q) begin
					status_d = STAT_NOT_FOUND;
				end else begin
					act_d   = ACT_DELETE;
					count_d = count_q - CNT_W'(1);
				end
			end
			default: begin
				status_d = STAT_OK;
			end
		endcase
	end

	// Controls broadcast to the chain.
	always_comb begin
		ctrl.search = (state_q == S_SEARCH);
		ctrl.act    = commit_go ? act_d : ACT_HOLD;
		last_d      = (count_d == '0) ? '0 : cell_value_nxt[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit_go) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_t'(opcode);
			key_q <= key;
			val_q <= new_value;
		end
		if (ctrl.search) begin
			hit_q <= |cell_match_nxt;
		end
		if (commit_go) begin
			status_q    <= status_d;
			count_out_q <= count_d;
			last_q      <= last_d;
		end
	end

	assign above_chain[CAPACITY] = 1'b0;

	for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
		logic signed [DATA_W-1:0] left_v;
		logic signed [DATA_W-1:0] right_v;
		logic                     left_m;

		if (j == 0) begin : g_tail
			assign left_v = val_q;
			assign left_m = 1'b0;
		end else begin : g_inner
			assign left_v = cell_value[j-1];
			assign left_m = cell_match[j-1];
		end

		if (j == CAPACITY - 1) begin : g_top
			assign right_v = '0;
		end else begin : g_below
			assign right_v = cell_value[j+1];
		end

		kli_cell #(
			.INDEX (j),
			.CNT_W (CNT_W)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.count       (count_q),
			.key         (key_q),
			.new_value   (val_q),
			.left_value  (left_v),
			.right_value (right_v),
			.left_match  (left_m),
			.above_in    (above_chain[j+1]),
			.above_out   (above_chain[j]),
			.match       (cell_match[j]),
			.match_nxt   (cell_match_nxt[j]),
			.value       (cell_value[j]),
			.value_nxt   (cell_value_nxt[j])
		);
	end

	assign count_ext  = (CNT_W + COUNT_W)'(count_out_q);
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign count      = count_ext[COUNT_W-1:0];
	assign last_value = last_q;

endmodule
